// ----- src/optimal_scalar_pair_matching_macros.svh -----
// Assertion macros shared by the matching block RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef OPTIMAL_SCALAR_PAIR_MATCHING_MACROS_SVH
`define OPTIMAL_SCALAR_PAIR_MATCHING_MACROS_SVH
// Condition must hold at every clock edge outside reset.
`define OSM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("osm assertion failed");
// Antecedent at one edge implies consequent at the next edge.
`define OSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("osm assertion failed");
`endif

// ----- src/osm_pkg.sv -----
// Shared types and codes for the scalar pair matching block.
// No dependencies; used by the interfaces, the matching module and the testbench.
package osm_pkg;
  localparam logic OP_TREATED = 1'b0;
  localparam logic OP_CONTROL = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] score;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [5:0] treated_index;
    logic [7:0] control_index;
    logic       error;
    logic       last_res;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SORT_A_RD, ST_SORT_A_LAT, ST_SORT_B_RD, ST_SORT_B_CMP, ST_SORT_WR,
    ST_ROW_START, ST_ROW_ORD, ST_ROW_TV, ST_CELL_A, ST_CELL_B, ST_CELL_C, ST_CELL_D,
    ST_BT_RD, ST_BT_CHK, ST_BT_T, ST_BT_C, ST_EMIT_RD, ST_EMIT_LAT, ST_EMIT_OUT,
    ST_ERR_OUT
  } state_t;
endpackage

// ----- src/osm_if.sv -----
// Valid/ready stream interfaces for the matching block channels.
// Depends on osm_pkg for the payload structs.
interface osm_in_if;
  logic              valid;
  logic              ready;
  osm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface osm_out_if;
  logic               valid;
  logic               ready;
  osm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/optimal_scalar_pair_matching.sv -----
// Optimal 1-D pair matching: load, stable sort, DP over sorted scores, backtrack.
// Depends on osm_pkg, osm_if.sv, osm_cell and optimal_scalar_pair_matching_macros.svh.
//
// Usage:
//   src_ch carries items {op, score, last}: op 0 is a treated score, op 1 a control
//   score. While loading, src_ch.ready is high and one item is taken per cycle.
//   The transfer with last set closes the data set; ready then drops until every
//   result of the run has been transferred on res_ch.
//   res_ch gives one result per treated item in treated arrival order, carrying
//   the arrival index of its matched control; last_res marks the final one. An
//   empty treated set, fewer controls than treated, or an overfull store gives a
//   single result with error set instead.
// Steps (nt treated, nc controls): the sort counts ranks with one compare at a time,
// the DP evaluates nt*(nc+1) - nt*(nt+1)/2 cells in the one shared DP cell unit,
// the backtrack walks skips and matches, and emit reads out one result at a time.
// A stalled receiver holds the current result on res_ch; nothing advances.
// Reset clears the counts, the overflow flag and the sequencer; no memory is
// cleared, every entry is written before it is read.
module optimal_scalar_pair_matching #(
  parameter int MAX_TREATED = 64,
  parameter int MAX_CONTROL = 256,
  parameter int SCORE_BITS  = 32
) (
  input logic           clk,
  input logic           rst,
  osm_in_if.sink        src_ch,
  osm_out_if.source     res_ch
);
`include "optimal_scalar_pair_matching_macros.svh"

  localparam int TIW    = (MAX_TREATED > 1) ? $clog2(MAX_TREATED) : 1;
  localparam int CIW    = (MAX_CONTROL > 1) ? $clog2(MAX_CONTROL) : 1;
  localparam int TCW    = $clog2(MAX_TREATED + 1);
  localparam int CCW    = $clog2(MAX_CONTROL + 1);
  localparam int CNW    = (TCW > CCW) ? TCW : CCW;
  localparam int OW     = (TIW > CIW) ? TIW : CIW;
  localparam int SDEPTH = MAX_TREATED + MAX_CONTROL;
  localparam int AW     = $clog2(SDEPTH);
  localparam int DW     = SCORE_BITS + 1;
  localparam int CW     = SCORE_BITS + 7;
  localparam int CHW    = TIW + CCW;

  // storage: scores and sorted orders share one address space, controls after treated
  logic signed [SCORE_BITS-1:0] score_mem [SDEPTH];
  logic [OW-1:0]                order_mem [SDEPTH];
  logic [CW:0]                  cost_mem  [2**(CCW+1)];
  logic                         choice_mem[2**CHW];
  logic [CIW-1:0]               match_mem [MAX_TREATED];

  logic [AW-1:0]  sm_raddr, sm_waddr, om_raddr, om_waddr;
  logic           sm_we, om_we, cm_we, ch_we, mm_we;
  logic signed [SCORE_BITS-1:0] sm_wdata, sm_rd;
  logic [OW-1:0]  om_wdata, om_rd;
  logic [CCW:0]   cm_raddr, cm_waddr;
  logic [CW:0]    cm_wdata, cm_rd;
  logic [CHW-1:0] ch_raddr, ch_waddr;
  logic           ch_wdata, ch_rd;
  logic [TIW-1:0] mm_raddr, mm_waddr;
  logic [CIW-1:0] mm_wdata, mm_rd;

  osm_pkg::state_t state, state_next;

  logic [TCW-1:0] tcnt, nt, i;
  logic [CCW-1:0] ccnt, nc, j;
  logic           ovf, sort_ctl, sel;
  logic [CNW-1:0] a, b, rank;
  logic signed [SCORE_BITS-1:0] va, tv, in_score;
  logic [TIW-1:0] tord, k;
  logic [CW-1:0]  prevc, skipc;
  logic           prevr, skipr;
  logic [DW-1:0]  diff;
  logic [CIW-1:0] out_ctrl;

  logic           in_xfer, out_xfer;
  logic           t_full, c_full, ovf_new, run_err;
  logic [TCW-1:0] nt_new;
  logic [CCW-1:0] nc_new;
  logic [CNW-1:0] sort_n;
  logic [AW-1:0]  sort_base;
  logic           cell_pick, cell_reach;
  logic [CW-1:0]  cell_cost;
  logic signed [DW-1:0] tv_x, cs_x;

  // reduce the 32-bit score to SCORE_BITS, sign-extending where wider
  generate
    if (SCORE_BITS <= 32) begin : g_narrow
      assign in_score = src_ch.data.score[SCORE_BITS-1:0];
    end else begin : g_wide
      assign in_score = {{(SCORE_BITS-32){src_ch.data.score[31]}}, src_ch.data.score};
    end
  endgenerate

  assign in_xfer  = src_ch.valid && src_ch.ready;
  assign out_xfer = res_ch.valid && res_ch.ready;

  assign t_full  = (tcnt == TCW'(MAX_TREATED));
  assign c_full  = (ccnt == CCW'(MAX_CONTROL));
  assign nt_new  = (src_ch.data.op == osm_pkg::OP_TREATED && !t_full) ? tcnt + 1'b1 : tcnt;
  assign nc_new  = (src_ch.data.op == osm_pkg::OP_CONTROL && !c_full) ? ccnt + 1'b1 : ccnt;
  assign ovf_new = ovf || ((src_ch.data.op == osm_pkg::OP_TREATED) ? t_full : c_full);
  assign run_err = ovf_new || (nt_new == '0) || (CNW'(nc_new) < CNW'(nt_new));

  assign sort_n    = sort_ctl ? CNW'(nc) : CNW'(nt);
  assign sort_base = sort_ctl ? AW'(MAX_TREATED) : '0;

  assign tv_x = DW'(tv);
  assign cs_x = DW'(sm_rd);

  osm_cell #(.CW(CW), .DW(DW)) u_cell (
    .prev_cost  (prevc),
    .prev_reach (prevr),
    .diff       (diff),
    .skip_cost  (skipc),
    .skip_reach (skipr),
    .pick       (cell_pick),
    .cost       (cell_cost),
    .reach      (cell_reach)
  );

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (sm_we) score_mem[sm_waddr] <= sm_wdata;
    sm_rd <= score_mem[sm_raddr];
    if (om_we) order_mem[om_waddr] <= om_wdata;
    om_rd <= order_mem[om_raddr];
    if (cm_we) cost_mem[cm_waddr] <= cm_wdata;
    cm_rd <= cost_mem[cm_raddr];
    if (ch_we) choice_mem[ch_waddr] <= ch_wdata;
    ch_rd <= choice_mem[ch_raddr];
    if (mm_we) match_mem[mm_waddr] <= mm_wdata;
    mm_rd <= match_mem[mm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= osm_pkg::ST_LOAD;
    else     state <= state_next;
  end

  // sequencer: next state and memory port control
  always_comb begin
    state_next = state;
    sm_raddr = '0; sm_waddr = '0; sm_we = 1'b0; sm_wdata = in_score;
    om_raddr = '0; om_waddr = sort_base + AW'(rank); om_we = 1'b0; om_wdata = OW'(a);
    cm_raddr = {~sel, CCW'(j - 1'b1)}; cm_waddr = {sel, j};
    cm_we = 1'b0; cm_wdata = {cell_reach, cell_cost};
    ch_raddr = {TIW'(i - 1'b1), j}; ch_waddr = {TIW'(i - 1'b1), j};
    ch_we = 1'b0; ch_wdata = cell_pick;
    mm_raddr = k; mm_waddr = tord; mm_we = 1'b0; mm_wdata = CIW'(om_rd);
    unique case (state)
      osm_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (src_ch.data.op == osm_pkg::OP_TREATED) begin
            sm_waddr = AW'(tcnt);
            sm_we    = !t_full;
          end else begin
            sm_waddr = AW'(MAX_TREATED) + AW'(ccnt);
            sm_we    = !c_full;
          end
          if (src_ch.data.last) begin
            state_next = run_err ? osm_pkg::ST_ERR_OUT : osm_pkg::ST_SORT_A_RD;
          end
        end
      end
      osm_pkg::ST_SORT_A_RD: begin
        sm_raddr   = sort_base + AW'(a);
        state_next = osm_pkg::ST_SORT_A_LAT;
      end
      osm_pkg::ST_SORT_A_LAT: state_next = osm_pkg::ST_SORT_B_RD;
      osm_pkg::ST_SORT_B_RD: begin
        sm_raddr   = sort_base + AW'(b);
        state_next = osm_pkg::ST_SORT_B_CMP;
      end
      osm_pkg::ST_SORT_B_CMP: begin
        state_next = (b == sort_n - 1'b1) ? osm_pkg::ST_SORT_WR : osm_pkg::ST_SORT_B_RD;
      end
      osm_pkg::ST_SORT_WR: begin
        om_we = 1'b1;
        if (a == sort_n - 1'b1) begin
          state_next = sort_ctl ? osm_pkg::ST_ROW_START : osm_pkg::ST_SORT_A_RD;
        end else begin
          state_next = osm_pkg::ST_SORT_A_RD;
        end
      end
      osm_pkg::ST_ROW_START: begin
        om_raddr   = AW'(i - 1'b1);
        state_next = osm_pkg::ST_ROW_ORD;
      end
      osm_pkg::ST_ROW_ORD: begin
        sm_raddr   = AW'(om_rd);
        state_next = osm_pkg::ST_ROW_TV;
      end
      osm_pkg::ST_ROW_TV: state_next = osm_pkg::ST_CELL_A;
      osm_pkg::ST_CELL_A: begin
        om_raddr   = AW'(MAX_TREATED) + AW'(j - 1'b1);
        state_next = osm_pkg::ST_CELL_B;
      end
      osm_pkg::ST_CELL_B: begin
        sm_raddr   = AW'(MAX_TREATED) + AW'(om_rd);
        state_next = osm_pkg::ST_CELL_C;
      end
      osm_pkg::ST_CELL_C: state_next = osm_pkg::ST_CELL_D;
      osm_pkg::ST_CELL_D: begin
        cm_we = 1'b1;
        ch_we = 1'b1;
        if (j == nc) begin
          state_next = (i == nt) ? osm_pkg::ST_BT_RD : osm_pkg::ST_ROW_START;
        end else begin
          state_next = osm_pkg::ST_CELL_A;
        end
      end
      osm_pkg::ST_BT_RD: state_next = osm_pkg::ST_BT_CHK;
      osm_pkg::ST_BT_CHK: begin
        om_raddr = AW'(i - 1'b1);
        if (ch_rd) begin
          state_next = osm_pkg::ST_BT_T;
        end else begin
          state_next = (j == CCW'(1)) ? osm_pkg::ST_EMIT_RD : osm_pkg::ST_BT_RD;
        end
      end
      osm_pkg::ST_BT_T: begin
        om_raddr   = AW'(MAX_TREATED) + AW'(j - 1'b1);
        state_next = osm_pkg::ST_BT_C;
      end
      osm_pkg::ST_BT_C: begin
        mm_we = 1'b1;
        state_next = (i == TCW'(1) || j == CCW'(1)) ? osm_pkg::ST_EMIT_RD
                                                    : osm_pkg::ST_BT_RD;
      end
      osm_pkg::ST_EMIT_RD: state_next = osm_pkg::ST_EMIT_LAT;
      osm_pkg::ST_EMIT_LAT: state_next = osm_pkg::ST_EMIT_OUT;
      osm_pkg::ST_EMIT_OUT: begin
        if (out_xfer) begin
          state_next = (k == TIW'(nt - 1'b1)) ? osm_pkg::ST_LOAD : osm_pkg::ST_EMIT_RD;
        end
      end
      osm_pkg::ST_ERR_OUT: begin
        if (out_xfer) state_next = osm_pkg::ST_LOAD;
      end
      default: state_next = osm_pkg::ST_LOAD;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tcnt <= '0;
      ccnt <= '0;
      ovf  <= 1'b0;
    end else if (state == osm_pkg::ST_LOAD && in_xfer) begin
      if (src_ch.data.last) begin
        tcnt <= '0;
        ccnt <= '0;
        ovf  <= 1'b0;
      end else begin
        tcnt <= nt_new;
        ccnt <= nc_new;
        ovf  <= ovf_new;
      end
    end
  end

  // datapath registers, advanced per sequencer step
  always_ff @(posedge clk) begin
    unique case (state)
      osm_pkg::ST_LOAD: begin
        nt       <= nt_new;
        nc       <= nc_new;
        sort_ctl <= 1'b0;
        a        <= '0;
      end
      osm_pkg::ST_SORT_A_LAT: begin
        va   <= sm_rd;
        b    <= '0;
        rank <= '0;
      end
      osm_pkg::ST_SORT_B_CMP: begin
        // stable rank: smaller scores, and equal scores that arrived earlier
        if ((sm_rd < va) || ((sm_rd == va) && (b < a))) rank <= rank + 1'b1;
        b <= b + 1'b1;
      end
      osm_pkg::ST_SORT_WR: begin
        if (a == sort_n - 1'b1) begin
          a        <= '0;
          sort_ctl <= 1'b1;
          i        <= TCW'(1);
          sel      <= 1'b0;
        end else begin
          a <= a + 1'b1;
        end
      end
      osm_pkg::ST_ROW_TV: begin
        tv    <= sm_rd;
        j     <= CCW'(i);
        skipc <= '0;
        skipr <= 1'b0;
      end
      osm_pkg::ST_CELL_B: begin
        // the first row reads as all zero and reachable
        if (i == TCW'(1)) begin
          prevc <= '0;
          prevr <= 1'b1;
        end else begin
          prevc <= cm_rd[CW-1:0];
          prevr <= cm_rd[CW];
        end
      end
      osm_pkg::ST_CELL_C: begin
        diff <= (tv >= sm_rd) ? DW'(tv_x - cs_x) : DW'(cs_x - tv_x);
      end
      osm_pkg::ST_CELL_D: begin
        skipc <= cell_cost;
        skipr <= cell_reach;
        if (j == nc) begin
          if (i == nt) begin
            j <= nc;
          end else begin
            i   <= i + 1'b1;
            sel <= ~sel;
          end
        end else begin
          j <= j + 1'b1;
        end
      end
      osm_pkg::ST_BT_CHK: begin
        k <= '0;
        if (!ch_rd) j <= j - 1'b1;
      end
      osm_pkg::ST_BT_T: tord <= TIW'(om_rd);
      osm_pkg::ST_BT_C: begin
        i <= i - 1'b1;
        j <= j - 1'b1;
      end
      osm_pkg::ST_EMIT_LAT: out_ctrl <= mm_rd;
      osm_pkg::ST_EMIT_OUT: begin
        if (out_xfer) k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign src_ch.ready = (state == osm_pkg::ST_LOAD);

  assign res_ch.valid = (state == osm_pkg::ST_EMIT_OUT) || (state == osm_pkg::ST_ERR_OUT);
  assign res_ch.data.treated_index = (state == osm_pkg::ST_ERR_OUT) ? '0 : 6'(k);
  assign res_ch.data.control_index = (state == osm_pkg::ST_ERR_OUT) ? '0 : 8'(out_ctrl);
  assign res_ch.data.error         = (state == osm_pkg::ST_ERR_OUT);
  assign res_ch.data.last_res      = (state == osm_pkg::ST_ERR_OUT) ||
                                     (k == TIW'(nt - 1'b1));

  `OSM_ASSERT_ALWAYS(a_count_bound, clk, rst,
    (tcnt <= TCW'(MAX_TREATED)) && (ccnt <= CCW'(MAX_CONTROL)))
  `OSM_ASSERT_NEXT(a_busy_after_last, clk, rst,
    in_xfer && src_ch.data.last, !src_ch.ready)
  `OSM_ASSERT_ALWAYS(a_cell_window, clk, rst,
    !(state == osm_pkg::ST_CELL_D) || ((CNW'(j) >= CNW'(i)) && (j <= nc)))
  `OSM_ASSERT_ALWAYS(a_bt_window, clk, rst,
    !(state == osm_pkg::ST_BT_CHK) || ((i != '0) && (CNW'(j) >= CNW'(i))))
endmodule

// ----- src/osm_cell.sv -----
// Shared DP cell unit: one add and one compare deciding take or skip.
// No package dependencies.
module osm_cell #(
  parameter int CW = 39,
  parameter int DW = 33
) (
  input  logic [CW-1:0] prev_cost,
  input  logic          prev_reach,
  input  logic [DW-1:0] diff,
  input  logic [CW-1:0] skip_cost,
  input  logic          skip_reach,
  output logic          pick,
  output logic [CW-1:0] cost,
  output logic          reach
);
  logic [CW-1:0] take;

  assign take  = prev_cost + CW'(diff);
  // take wins ties; an unreachable skip always loses
  assign pick  = !skip_reach || (prev_reach && (take <= skip_cost));
  assign cost  = pick ? take : skip_cost;
  assign reach = pick ? prev_reach : skip_reach;
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for optimal_scalar_pair_matching: random and directed data sets.
// Depends on osm_pkg and the stream interfaces in osm_if.sv, and on the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT_CAP = 64;
  localparam int NC_CAP = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;

  osm_in_if  src_ch ();
  osm_out_if res_ch ();

  optimal_scalar_pair_matching i_dut (
    .clk    (clk),
    .rst    (rst),
    .src_ch (src_ch),
    .res_ch (res_ch)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and matches waiting to come out.
  osm_pkg::in_item_t  pend_items[$];
  osm_pkg::out_item_t want_matches[$];

  int n_total;
  int n_accepted;
  int n_results;
  int n_sets;
  int n_err_sets;
  int n_fail;
  bit in_fire;

  // Shadow copy of the loading state of the block.
  longint  trt_score[NT_CAP];
  longint  ctl_score[NC_CAP];
  int      trt_cnt;
  int      ctl_cnt;
  bit      cap_over;

  // Stable ascending sort of indexes 0..n-1 by score.
  function automatic void rank_scores(input longint val[], input int n, ref int ord[]);
    int a;
    int b;
    int key;
    ord = new[n];
    for (a = 0; a < n; a++) ord[a] = a;
    for (a = 1; a < n; a++) begin
      key = ord[a];
      b = a;
      while (b > 0 && val[ord[b-1]] > val[key]) begin
        ord[b] = ord[b-1];
        b--;
      end
      ord[b] = key;
    end
  endfunction

  function automatic longint unsigned gap(input longint x, input longint y);
    return (x >= y) ? longint'(x - y) : longint'(y - x);
  endfunction

  // Minimum-cost pairing by DP over both sorted sets, then backtrack.
  function automatic void pair_up(input int nt, input int nc);
    longint             tv[];
    longint             cv[];
    int                 t_ord[];
    int                 c_ord[];
    longint unsigned    prev_c[NC_CAP+1];
    longint unsigned    cur_c[NC_CAP+1];
    bit                 prev_r[NC_CAP+1];
    bit                 cur_r[NC_CAP+1];
    bit                 took[NT_CAP+1][NC_CAP+1];
    int                 partner[NT_CAP];
    longint unsigned    take_c;
    bit                 pick;
    int                 i;
    int                 j;
    osm_pkg::out_item_t r;
    tv = new[nt];
    cv = new[nc];
    for (i = 0; i < nt; i++) tv[i] = trt_score[i];
    for (j = 0; j < nc; j++) cv[j] = ctl_score[j];
    rank_scores(tv, nt, t_ord);
    rank_scores(cv, nc, c_ord);
    for (j = 0; j <= nc; j++) begin
      prev_c[j] = 0;
      prev_r[j] = 1'b1;
    end
    for (i = 1; i <= nt; i++) begin
      for (j = 0; j < i; j++) begin
        cur_c[j] = 0;
        cur_r[j] = 1'b0;
      end
      for (j = i; j <= nc; j++) begin
        take_c = prev_c[j-1] + gap(tv[t_ord[i-1]], cv[c_ord[j-1]]);
        // take wins a tie against skip
        pick = !cur_r[j-1] || (prev_r[j-1] && take_c <= cur_c[j-1]);
        if (pick) begin
          cur_c[j] = take_c;
          cur_r[j] = prev_r[j-1];
        end else begin
          cur_c[j] = cur_c[j-1];
          cur_r[j] = cur_r[j-1];
        end
        took[i][j] = pick;
      end
      prev_c = cur_c;
      prev_r = cur_r;
    end
    i = nt;
    j = nc;
    while (i > 0 && j > 0) begin
      if (took[i][j]) begin
        partner[t_ord[i-1]] = c_ord[j-1];
        i--;
      end
      j--;
    end
    for (i = 0; i < nt; i++) begin
      r.treated_index = 6'(i);
      r.control_index = 8'(partner[i]);
      r.error         = 1'b0;
      r.last_res      = (i == nt - 1);
      want_matches.push_back(r);
    end
  endfunction

  // Absorb one accepted item; close the data set on last.
  function automatic void absorb(input osm_pkg::in_item_t it);
    int                 nt;
    int                 nc;
    osm_pkg::out_item_t r;
    if (it.op == osm_pkg::OP_TREATED) begin
      if (trt_cnt < NT_CAP) trt_score[trt_cnt++] = longint'(signed'(it.score));
      else cap_over = 1'b1;
    end else begin
      if (ctl_cnt < NC_CAP) ctl_score[ctl_cnt++] = longint'(signed'(it.score));
      else cap_over = 1'b1;
    end
    if (!it.last) return;
    nt = trt_cnt;
    nc = ctl_cnt;
    trt_cnt = 0;
    ctl_cnt = 0;
    n_sets++;
    if (cap_over || nt == 0 || nc < nt) begin
      cap_over = 1'b0;
      n_err_sets++;
      r = '0;
      r.error = 1'b1;
      r.last_res = 1'b1;
      want_matches.push_back(r);
    end else begin
      pair_up(nt, nc);
    end
  endfunction

  // Sample transfers on the input side and run the prediction.
  always @(posedge clk) begin
    in_fire <= !rst && src_ch.valid && src_ch.ready;
    if (!rst && src_ch.valid && src_ch.ready) begin
      n_accepted++;
      absorb(src_ch.data);
    end
  end

  // Idle percentages: first sender 33 / receiver 61, then swapped, then none.
  function automatic int idle_pct(input bit receiver);
    if (n_accepted < n_total / 3) return receiver ? 61 : 33;
    if (n_accepted < 2 * n_total / 3) return receiver ? 33 : 61;
    return 0;
  endfunction

  // Driver: hold the item until its transfer, then advance or idle.
  always @(negedge clk) begin
    if (!rst && (!src_ch.valid || in_fire)) begin
      if (pend_items.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        src_ch.data  <= pend_items.pop_front();
        src_ch.valid <= 1'b1;
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the input backs up.
  int  hold_left;
  bit  held_once;
  always @(negedge clk) begin
    if (!rst) begin
      if (!held_once && n_sets >= 12 && res_ch.valid) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // Monitor: compare every result transfer with the oldest expected match.
  always @(posedge clk) begin
    osm_pkg::out_item_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (want_matches.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result t=%0d c=%0d err=%0b last=%0b", $realtime,
                 res_ch.data.treated_index, res_ch.data.control_index,
                 res_ch.data.error, res_ch.data.last_res);
      end else begin
        w = want_matches.pop_front();
        if (res_ch.data.treated_index !== w.treated_index ||
            res_ch.data.control_index !== w.control_index ||
            res_ch.data.error !== w.error || res_ch.data.last_res !== w.last_res) begin
          n_fail++;
          $display("%0t: mismatch exp t=%0d c=%0d err=%0b last=%0b got t=%0d c=%0d err=%0b last=%0b",
                   $realtime, w.treated_index, w.control_index, w.error, w.last_res,
                   res_ch.data.treated_index, res_ch.data.control_index,
                   res_ch.data.error, res_ch.data.last_res);
        end
      end
    end
  end

  function automatic logic [31:0] pick_score(input bit wide);
    return wide ? 32'($urandom) : 32'($urandom_range(16) - 8);
  endfunction

  // Queue one data set of nt treated and nc control scores in shuffled order.
  task automatic add_set(input int nt, input int nc, input bit wide);
    logic              ops[];
    logic              tmp;
    int                k;
    int                s;
    osm_pkg::in_item_t it;
    ops = new[nt + nc];
    for (k = 0; k < nt + nc; k++) begin
      ops[k] = (k < nt) ? osm_pkg::OP_TREATED : osm_pkg::OP_CONTROL;
    end
    for (k = nt + nc - 1; k > 0; k--) begin
      s = $urandom_range(k);
      tmp = ops[k];
      ops[k] = ops[s];
      ops[s] = tmp;
    end
    for (k = 0; k < nt + nc; k++) begin
      it.op    = ops[k];
      it.score = pick_score(wide);
      it.last  = (k == nt + nc - 1);
      pend_items.push_back(it);
    end
  endtask

  // Queue one directed item.
  task automatic put(input logic op, input logic [31:0] sc, input logic lst);
    osm_pkg::in_item_t it;
    it.op = op;
    it.score = sc;
    it.last = lst;
    pend_items.push_back(it);
  endtask

  initial begin
    int nt;
    int nc;
    bit full_done;
    bit over_done;
    src_ch.valid = 1'b0;
    src_ch.data  = '0;
    res_ch.ready = 1'b0;
    full_done    = 1'b0;
    over_done    = 1'b0;

    // Directed: treated only, controls only.
    put(osm_pkg::OP_TREATED, 32'd0, 1'b1);
    put(osm_pkg::OP_CONTROL, 32'd5, 1'b1);
    // Plain case with an exact hit.
    put(osm_pkg::OP_TREATED, 32'd10, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd3, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd12, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd10, 1'b1);
    // Equal scores everywhere: arrival order decides.
    put(osm_pkg::OP_TREATED, 32'd7, 1'b0);
    put(osm_pkg::OP_TREATED, 32'd7, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd7, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd7, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd7, 1'b1);
    // Score extremes, widest differences.
    put(osm_pkg::OP_TREATED, 32'h7fff_ffff, 1'b0);
    put(osm_pkg::OP_TREATED, 32'h8000_0000, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'h8000_0000, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'h7fff_ffff, 1'b1);
    // Take and skip cost the same.
    put(osm_pkg::OP_TREATED, 32'd0, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'hffff_ffff, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd1, 1'b1);
    // As many controls as treated.
    put(osm_pkg::OP_TREATED, 32'd3, 1'b0);
    put(osm_pkg::OP_TREATED, 32'd1, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd2, 1'b0);
    put(osm_pkg::OP_CONTROL, 32'd0, 1'b1);

    // Random: mostly small sets, some broken counts, one set that fills the treated
    // store and one set that overfills it.
    while (pend_items.size() < 430) begin
      if (!full_done && pend_items.size() >= 80) begin
        add_set(NT_CAP, NT_CAP, 1'b1);
        full_done = 1'b1;
      end else if (!over_done && pend_items.size() >= 260) begin
        add_set(NT_CAP + 1, 1, 1'b0);
        over_done = 1'b1;
      end else begin
        nt = $urandom_range(1, 6);
        nc = nt + $urandom_range(0, 8);
        if ($urandom_range(9) == 0) nc = $urandom_range(0, nt - 1);
        if ($urandom_range(19) == 0) nt = 0;
        if (nt + nc == 0) nc = 1;
        add_set(nt, nc, $urandom_range(1));
      end
    end
    n_total = pend_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pend_items.size() == 0 && n_accepted == n_total);
    wait (want_matches.size() == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d items in %0d data sets (%0d ending in error), %0d results",
             n_accepted, n_sets, n_err_sets, n_results);
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #60_000_000;
    $display("timeout with %0d results still expected", want_matches.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
